/* rtl/ispf_pkg.sv */
// Package for the IMU serial frame parser: frame constants, result codes,
// the frame record passed from front to back, and the kind-to-scale table.
// No dependencies.
package ispf_pkg;

    localparam int FRAME_BYTES = 11;
    localparam int POS_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 16;
    localparam int DATA_BYTES  = 8;
    localparam int SCALE_W     = 11;
    localparam int PROD_W      = RAW_W + SCALE_W + 1;
    localparam int AXIS_W      = 27;
    localparam int TEMP_W      = 16;
    localparam int CNT_W       = 32;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] KIND_BYTE_ACCEL = 8'h51;
    localparam logic [BYTE_W-1:0] KIND_BYTE_RATE  = 8'h52;
    localparam logic [BYTE_W-1:0] KIND_BYTE_ANGLE = 8'h53;

    localparam logic [SCALE_W-1:0] SCALE_ACCEL = 11'd16;
    localparam logic [SCALE_W-1:0] SCALE_RATE  = 11'd2000;
    localparam logic [SCALE_W-1:0] SCALE_ANGLE = 11'd180;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_BAD_SUM = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } kind_t;

    typedef struct packed {
        status_t                  status;
        kind_t                    kind;
        logic signed [RAW_W-1:0]  raw_x;
        logic signed [RAW_W-1:0]  raw_y;
        logic signed [RAW_W-1:0]  raw_z;
        logic signed [RAW_W-1:0]  raw_t;
    } frame_rec_t;

    typedef struct packed {
        logic       push;
        frame_rec_t rec;
    } fq_req_t;

    typedef struct packed {
        logic       valid;
        logic       full;
        frame_rec_t rec;
    } q_head_t;

    function automatic logic [SCALE_W-1:0] kind_scale(kind_t kind);
        logic [SCALE_W-1:0] scale;
        unique case (kind)
            KIND_ACCEL: scale = SCALE_ACCEL;
            KIND_RATE:  scale = SCALE_RATE;
            KIND_ANGLE: scale = SCALE_ANGLE;
            default:    scale = '0;
        endcase
        return scale;
    endfunction

endpackage

/* rtl/imu_serial_frame_parser.sv */
// Top level of the IMU serial frame parser: front end, record queue, back end.
// Uses ispf_pkg, ispf_front, ispf_queue, ispf_back.
//
// channel   direction  handshake                  payload
// rx        in         rx_valid / rx_stall        rx_byte
// frame     out        frame_valid / frame_stall  frame_status .. bad_checksums
// cfg       in         cfg_we                     cfg_wdata (header byte)
//
// One byte is taken per cycle while rx_stall is low; a frame result passes through the
// record queue and the registered result stage before frame_valid rises.
// The two-entry record queue stalls rx only when full, so rx_stall rises only after
// two results back up behind a stalled frame output.
// Reset clears position, counters, queue and output valid; header returns to 0x55.
module imu_serial_frame_parser (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ispf_pkg::BYTE_W-1:0]          cfg_wdata,
    input  logic                                 rx_valid,
    output logic                                 rx_stall,
    input  logic [ispf_pkg::BYTE_W-1:0]          rx_byte,
    output logic                                 frame_valid,
    input  logic                                 frame_stall,
    output logic [1:0]                           frame_status,
    output logic [1:0]                           frame_kind,
    output logic signed [ispf_pkg::AXIS_W-1:0]   axis_x,
    output logic signed [ispf_pkg::AXIS_W-1:0]   axis_y,
    output logic signed [ispf_pkg::AXIS_W-1:0]   axis_z,
    output logic signed [ispf_pkg::TEMP_W-1:0]   temperature_centi,
    output logic                                 temperature_valid,
    output logic [ispf_pkg::CNT_W-1:0]           good_frames,
    output logic [ispf_pkg::CNT_W-1:0]           bad_checksums
);

    ispf_pkg::fq_req_t  req;
    ispf_pkg::q_head_t  head;
    logic               pop;
    logic               rx_accept;

    assign rx_stall  = head.full;
    assign rx_accept = rx_valid && !rx_stall;

    ispf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (rx_accept),
        .rx_byte   (rx_byte),
        .req       (req)
    );

    ispf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pop   (pop),
        .head  (head)
    );

    ispf_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .pop               (pop),
        .frame_valid       (frame_valid),
        .frame_stall       (frame_stall),
        .frame_status      (frame_status),
        .frame_kind        (frame_kind),
        .axis_x            (axis_x),
        .axis_y            (axis_y),
        .axis_z            (axis_z),
        .temperature_centi (temperature_centi),
        .temperature_valid (temperature_valid),
        .good_frames       (good_frames),
        .bad_checksums     (bad_checksums)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        head.full |-> !req.push)
        else $error("frame record pushed into full queue");

    a_bad_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_status != ispf_pkg::ST_GOOD) |->
        (axis_x == '0 && axis_y == '0 && axis_z == '0 && !temperature_valid))
        else $error("failed frame carries axis or temperature data");

    a_good_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (good_frames == $past(good_frames)
                 + ispf_pkg::CNT_W'($past(head.rec.status) == ispf_pkg::ST_GOOD)))
        else $error("good frame counter out of step with results");

    a_angle_no_temp: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_kind == ispf_pkg::KIND_ANGLE) |-> !temperature_valid)
        else $error("angle frame marked with temperature");

endmodule

/* rtl/ispf_front.sv */
// Front end of the frame parser: header hunt, byte position, running checksum,
// kind decode and frame record build. Uses ispf_pkg.
module ispf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ispf_pkg::BYTE_W-1:0]   cfg_wdata,
    input  logic                          accept,
    input  logic [ispf_pkg::BYTE_W-1:0]   rx_byte,
    output ispf_pkg::fq_req_t             req
);

    logic [ispf_pkg::BYTE_W-1:0]                      header_reg;
    logic [ispf_pkg::POS_W-1:0]                       pos_reg, pos_next, pos_eff;
    logic [ispf_pkg::BYTE_W-1:0]                      sum_reg, sum_next;
    logic [ispf_pkg::DATA_BYTES*ispf_pkg::BYTE_W-1:0] data_reg, data_next;
    ispf_pkg::kind_t                                  kind_reg, kind_next;
    logic                                             known_reg, known_next;
    ispf_pkg::status_t                                status;
    logic                                             push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= ispf_pkg::HEADER_RESET;
            pos_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                header_reg <= cfg_wdata;
            end
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        data_reg  <= data_next;
        kind_reg  <= kind_next;
        known_reg <= known_next;
    end

    always_comb
    begin
        pos_eff    = (pos_reg >= ispf_pkg::POS_W'(ispf_pkg::FRAME_BYTES)) ? '0 : pos_reg;
        pos_next   = pos_eff;
        sum_next   = sum_reg;
        data_next  = data_reg;
        kind_next  = kind_reg;
        known_next = known_reg;
        push       = 1'b0;
        if (accept)
        begin
            if (pos_eff == '0)
            begin
                if (rx_byte == header_reg)
                begin
                    sum_next = rx_byte;
                    pos_next = ispf_pkg::POS_W'(1);
                end
            end
            else if (pos_eff == ispf_pkg::POS_W'(ispf_pkg::FRAME_BYTES - 1))
            begin
                push     = 1'b1;
                pos_next = '0;
            end
            else
            begin
                sum_next = sum_reg + rx_byte;
                pos_next = pos_eff + 1'b1;
                if (pos_eff == ispf_pkg::POS_W'(1))
                begin
                    unique case (rx_byte)
                        ispf_pkg::KIND_BYTE_ACCEL:
                        begin
                            kind_next  = ispf_pkg::KIND_ACCEL;
                            known_next = 1'b1;
                        end
                        ispf_pkg::KIND_BYTE_RATE:
                        begin
                            kind_next  = ispf_pkg::KIND_RATE;
                            known_next = 1'b1;
                        end
                        ispf_pkg::KIND_BYTE_ANGLE:
                        begin
                            kind_next  = ispf_pkg::KIND_ANGLE;
                            known_next = 1'b1;
                        end
                        default:
                        begin
                            kind_next  = ispf_pkg::KIND_ACCEL;
                            known_next = 1'b0;
                        end
                    endcase
                end
                else
                begin
                    data_next = {rx_byte, data_reg[ispf_pkg::DATA_BYTES*ispf_pkg::BYTE_W-1:
                                                   ispf_pkg::BYTE_W]};
                end
            end
        end
    end

    always_comb
    begin
        if (sum_reg != rx_byte)
        begin
            status = ispf_pkg::ST_BAD_SUM;
        end
        else if (known_reg)
        begin
            status = ispf_pkg::ST_GOOD;
        end
        else
        begin
            status = ispf_pkg::ST_UNKNOWN;
        end
    end

    assign req.push       = push;
    assign req.rec.status = status;
    assign req.rec.kind   = kind_reg;
    assign req.rec.raw_x  = $signed(data_reg[15:0]);
    assign req.rec.raw_y  = $signed(data_reg[31:16]);
    assign req.rec.raw_z  = $signed(data_reg[47:32]);
    assign req.rec.raw_t  = $signed(data_reg[63:48]);

endmodule

/* rtl/ispf_queue.sv */
// Short frame record queue between the parser front and back.
// Uses ispf_pkg.
module ispf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  ispf_pkg::fq_req_t   req,
    input  logic                pop,
    output ispf_pkg::q_head_t   head
);

    ispf_pkg::frame_rec_t               mem [ispf_pkg::Q_DEPTH];
    logic [ispf_pkg::Q_PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [ispf_pkg::Q_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                               do_push, do_pop;

    assign do_push = req.push && (cnt_reg != ispf_pkg::Q_CNT_W'(ispf_pkg::Q_DEPTH));
    assign do_pop  = pop && (cnt_reg != '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == ispf_pkg::Q_PTR_W'(ispf_pkg::Q_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == ispf_pkg::Q_PTR_W'(ispf_pkg::Q_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= req.rec;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.full  = (cnt_reg == ispf_pkg::Q_CNT_W'(ispf_pkg::Q_DEPTH));
    assign head.rec   = mem[rd_ptr_reg];

endmodule

/* rtl/ispf_back.sv */
// Back end of the frame parser: axis scaling, frame counters and the
// registered result stage. Uses ispf_pkg.
module ispf_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ispf_pkg::q_head_t                    head,
    output logic                                 pop,
    output logic                                 frame_valid,
    input  logic                                 frame_stall,
    output logic [1:0]                           frame_status,
    output logic [1:0]                           frame_kind,
    output logic signed [ispf_pkg::AXIS_W-1:0]   axis_x,
    output logic signed [ispf_pkg::AXIS_W-1:0]   axis_y,
    output logic signed [ispf_pkg::AXIS_W-1:0]   axis_z,
    output logic signed [ispf_pkg::TEMP_W-1:0]   temperature_centi,
    output logic                                 temperature_valid,
    output logic [ispf_pkg::CNT_W-1:0]           good_frames,
    output logic [ispf_pkg::CNT_W-1:0]           bad_checksums
);

    logic                                   valid_reg;
    logic [ispf_pkg::CNT_W-1:0]             good_cnt_reg, good_cnt_next;
    logic [ispf_pkg::CNT_W-1:0]             bad_cnt_reg, bad_cnt_next;
    ispf_pkg::status_t                      status_reg;
    ispf_pkg::kind_t                        kind_reg, kind_next;
    logic signed [ispf_pkg::AXIS_W-1:0]     x_reg, y_reg, z_reg, x_next, y_next, z_next;
    logic signed [ispf_pkg::TEMP_W-1:0]     temp_reg, temp_next;
    logic                                   temp_ok_reg, temp_ok_next;
    logic signed [ispf_pkg::SCALE_W:0]      scale_s;
    logic signed [ispf_pkg::PROD_W-1:0]     px, py, pz;
    logic                                   is_good;

    assign pop     = head.valid && (!valid_reg || !frame_stall);
    assign is_good = (head.rec.status == ispf_pkg::ST_GOOD);
    assign scale_s = $signed({1'b0, ispf_pkg::kind_scale(head.rec.kind)});
    assign px      = head.rec.raw_x * scale_s;
    assign py      = head.rec.raw_y * scale_s;
    assign pz      = head.rec.raw_z * scale_s;

    always_comb
    begin
        good_cnt_next = good_cnt_reg;
        bad_cnt_next  = bad_cnt_reg;
        kind_next     = ispf_pkg::KIND_ACCEL;
        x_next        = '0;
        y_next        = '0;
        z_next        = '0;
        temp_next     = '0;
        temp_ok_next  = 1'b0;
        if (pop)
        begin
            if (head.rec.status == ispf_pkg::ST_BAD_SUM)
            begin
                bad_cnt_next = bad_cnt_reg + 1'b1;
            end
            if (is_good)
            begin
                good_cnt_next = good_cnt_reg + 1'b1;
            end
        end
        if (is_good)
        begin
            kind_next = head.rec.kind;
            x_next    = $signed(px[ispf_pkg::AXIS_W-1:0]);
            y_next    = $signed(py[ispf_pkg::AXIS_W-1:0]);
            z_next    = $signed(pz[ispf_pkg::AXIS_W-1:0]);
            if (head.rec.kind != ispf_pkg::KIND_ANGLE)
            begin
                temp_next    = head.rec.raw_t;
                temp_ok_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            good_cnt_reg <= '0;
            bad_cnt_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
            end
            else if (!frame_stall)
            begin
                valid_reg <= 1'b0;
            end
            good_cnt_reg <= good_cnt_next;
            bad_cnt_reg  <= bad_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg  <= head.rec.status;
            kind_reg    <= kind_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            z_reg       <= z_next;
            temp_reg    <= temp_next;
            temp_ok_reg <= temp_ok_next;
        end
    end

    assign frame_valid       = valid_reg;
    assign frame_status      = status_reg;
    assign frame_kind        = kind_reg;
    assign axis_x            = x_reg;
    assign axis_y            = y_reg;
    assign axis_z            = z_reg;
    assign temperature_centi = temp_reg;
    assign temperature_valid = temp_ok_reg;
    assign good_frames       = good_cnt_reg;
    assign bad_checksums     = bad_cnt_reg;

endmodule

/* bench/imu_serial_frame_parser_test.sv */
// Testbench for imu_serial_frame_parser: directed and random byte streams are
// sent (most random runs with random idling on both sides); every frame result
// is checked against a predictor in this file. Depends on ispf_pkg and the block RTL.
module imu_serial_frame_parser_test;

    typedef struct {
        ispf_pkg::status_t                   status;
        ispf_pkg::kind_t                     kind;
        logic signed [ispf_pkg::AXIS_W-1:0]  x;
        logic signed [ispf_pkg::AXIS_W-1:0]  y;
        logic signed [ispf_pkg::AXIS_W-1:0]  z;
        logic signed [ispf_pkg::TEMP_W-1:0]  temp;
        logic                                temp_ok;
        logic [ispf_pkg::CNT_W-1:0]          good;
        logic [ispf_pkg::CNT_W-1:0]          bad;
    } frame_result_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_we = 1'b0;
    logic [ispf_pkg::BYTE_W-1:0]           cfg_wdata = '0;
    logic                                  rx_valid = 1'b0;
    logic                                  rx_stall;
    logic [ispf_pkg::BYTE_W-1:0]           rx_byte = '0;
    logic                                  frame_valid;
    logic                                  frame_stall = 1'b0;
    logic [1:0]                            frame_status;
    logic [1:0]                            frame_kind;
    logic signed [ispf_pkg::AXIS_W-1:0]    axis_x;
    logic signed [ispf_pkg::AXIS_W-1:0]    axis_y;
    logic signed [ispf_pkg::AXIS_W-1:0]    axis_z;
    logic signed [ispf_pkg::TEMP_W-1:0]    temperature_centi;
    logic                                  temperature_valid;
    logic [ispf_pkg::CNT_W-1:0]            good_frames;
    logic [ispf_pkg::CNT_W-1:0]            bad_checksums;

    frame_result_t               pending_frames[$];
    logic [ispf_pkg::BYTE_W-1:0] header_now = ispf_pkg::HEADER_RESET;
    logic [ispf_pkg::BYTE_W-1:0] frame_bytes_held [ispf_pkg::FRAME_BYTES];
    int                          bytes_held = 0;
    logic [ispf_pkg::CNT_W-1:0]  good_count = '0;
    logic [ispf_pkg::CNT_W-1:0]  bad_count = '0;
    int                          mismatches = 0;
    int                          bytes_sent = 0;
    int                          send_idle_pct = 0;
    int                          recv_idle_pct = 0;

    imu_serial_frame_parser uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .rx_valid          (rx_valid),
        .rx_stall          (rx_stall),
        .rx_byte           (rx_byte),
        .frame_valid       (frame_valid),
        .frame_stall       (frame_stall),
        .frame_status      (frame_status),
        .frame_kind        (frame_kind),
        .axis_x            (axis_x),
        .axis_y            (axis_y),
        .axis_z            (axis_z),
        .temperature_centi (temperature_centi),
        .temperature_valid (temperature_valid),
        .good_frames       (good_frames),
        .bad_checksums     (bad_checksums)
    );

    always #5 clk = ~clk;

    function automatic logic signed [ispf_pkg::AXIS_W-1:0] scaled_axis(
        input logic [ispf_pkg::BYTE_W-1:0] lo,
        input logic [ispf_pkg::BYTE_W-1:0] hi,
        input int scale);
        logic signed [ispf_pkg::RAW_W-1:0] raw;
        int                                prod;
        raw = {hi, lo};
        prod = raw * scale;
        return prod[ispf_pkg::AXIS_W-1:0];
    endfunction

    task automatic track_byte(input logic [ispf_pkg::BYTE_W-1:0] b);
        frame_result_t               r;
        logic [ispf_pkg::BYTE_W-1:0] sum;
        int                          scale;
        if (bytes_held == 0)
        begin
            if (b == header_now)
            begin
                frame_bytes_held[0] = b;
                bytes_held = 1;
            end
        end
        else
        begin
            frame_bytes_held[bytes_held] = b;
            bytes_held++;
            if (bytes_held == ispf_pkg::FRAME_BYTES)
            begin
                bytes_held = 0;
                sum = '0;
                for (int i = 0; i < ispf_pkg::FRAME_BYTES - 1; i++)
                    sum = sum + frame_bytes_held[i];
                r.status = ispf_pkg::ST_GOOD;
                r.kind = ispf_pkg::KIND_ACCEL;
                r.x = '0;
                r.y = '0;
                r.z = '0;
                r.temp = '0;
                r.temp_ok = 1'b0;
                scale = 0;
                if (sum != frame_bytes_held[ispf_pkg::FRAME_BYTES-1])
                begin
                    bad_count++;
                    r.status = ispf_pkg::ST_BAD_SUM;
                end
                else
                begin
                    case (frame_bytes_held[1])
                        ispf_pkg::KIND_BYTE_ACCEL:
                        begin
                            scale = ispf_pkg::SCALE_ACCEL;
                            r.kind = ispf_pkg::KIND_ACCEL;
                        end
                        ispf_pkg::KIND_BYTE_RATE:
                        begin
                            scale = ispf_pkg::SCALE_RATE;
                            r.kind = ispf_pkg::KIND_RATE;
                        end
                        ispf_pkg::KIND_BYTE_ANGLE:
                        begin
                            scale = ispf_pkg::SCALE_ANGLE;
                            r.kind = ispf_pkg::KIND_ANGLE;
                        end
                        default:
                        begin
                            scale = 0;
                        end
                    endcase
                    if (scale == 0)
                    begin
                        r.status = ispf_pkg::ST_UNKNOWN;
                        r.kind = ispf_pkg::KIND_ACCEL;
                    end
                    else
                    begin
                        good_count++;
                        r.x = scaled_axis(frame_bytes_held[2], frame_bytes_held[3], scale);
                        r.y = scaled_axis(frame_bytes_held[4], frame_bytes_held[5], scale);
                        r.z = scaled_axis(frame_bytes_held[6], frame_bytes_held[7], scale);
                        if (r.kind != ispf_pkg::KIND_ANGLE)
                        begin
                            r.temp = {frame_bytes_held[9], frame_bytes_held[8]};
                            r.temp_ok = 1'b1;
                        end
                    end
                end
                r.good = good_count;
                r.bad = bad_count;
                pending_frames.push_back(r);
            end
        end
    endtask

    task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h actual %0h", what, want, got);
    endtask

    task automatic check_frame();
        frame_result_t e;
        if (pending_frames.size() == 0)
        begin
            flag("unexpected frame, status", 64'h0, 64'(frame_status));
        end
        else
        begin
            e = pending_frames.pop_front();
            if (frame_status !== e.status)
                flag("frame_status", 64'(e.status), 64'(frame_status));
            if (frame_kind !== e.kind)
                flag("frame_kind", 64'(e.kind), 64'(frame_kind));
            if (axis_x !== e.x)
                flag("axis_x", 64'(e.x), 64'(axis_x));
            if (axis_y !== e.y)
                flag("axis_y", 64'(e.y), 64'(axis_y));
            if (axis_z !== e.z)
                flag("axis_z", 64'(e.z), 64'(axis_z));
            if (temperature_centi !== e.temp)
                flag("temperature_centi", 64'(e.temp), 64'(temperature_centi));
            if (temperature_valid !== e.temp_ok)
                flag("temperature_valid", 64'(e.temp_ok), 64'(temperature_valid));
            if (good_frames !== e.good)
                flag("good_frames", 64'(e.good), 64'(good_frames));
            if (bad_checksums !== e.bad)
                flag("bad_checksums", 64'(e.bad), 64'(bad_checksums));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_valid && !frame_stall)
                check_frame();
            frame_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [ispf_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        track_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [ispf_pkg::BYTE_W-1:0] kind_byte,
                              input logic [63:0] data, input bit corrupt);
        logic [ispf_pkg::BYTE_W-1:0] sum;
        logic [ispf_pkg::BYTE_W-1:0] spoil;
        sum = header_now + kind_byte;
        send_byte(header_now);
        send_byte(kind_byte);
        for (int i = 0; i < ispf_pkg::DATA_BYTES; i++)
        begin
            sum = sum + data[8*i +: 8];
            send_byte(data[8*i +: 8]);
        end
        spoil = 8'($urandom_range(1, 255));
        send_byte(corrupt ? sum ^ spoil : sum);
    endtask

    task automatic drain();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_header(input logic [ispf_pkg::BYTE_W-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        header_now = value;
        @(posedge clk);
    endtask

    task automatic test_known_kinds();
        send_frame(ispf_pkg::KIND_BYTE_ACCEL, 64'hFFFF_0000_8000_7FFF, 1'b0);
        send_frame(ispf_pkg::KIND_BYTE_RATE, 64'h8000_FFFF_7FFF_8000, 1'b0);
        send_frame(ispf_pkg::KIND_BYTE_ANGLE, 64'h1234_0001_7FFF_8000, 1'b0);
    endtask

    task automatic test_bad_checksum();
        send_frame(ispf_pkg::KIND_BYTE_ACCEL, 64'h0102_0304_0506_0708, 1'b1);
    endtask

    task automatic test_unknown_kind();
        send_frame(8'h00, 64'h7FFF_8000_7FFF_8000, 1'b0);
    endtask

    task automatic test_header_inside_frame();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(ispf_pkg::KIND_BYTE_ACCEL, {8{ispf_pkg::HEADER_RESET}}, 1'b0);
    endtask

    task automatic test_header_values();
        set_header(8'h00);
        send_frame(ispf_pkg::KIND_BYTE_RATE, 64'h0000_0000_0000_0000, 1'b0);
        set_header(8'hFF);
        send_byte(8'h55);
        send_frame(ispf_pkg::KIND_BYTE_ANGLE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        set_header(ispf_pkg::KIND_BYTE_ACCEL);
        send_frame(ispf_pkg::KIND_BYTE_ACCEL, 64'h5151_5151_5151_5151, 1'b0);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        int                          stop_at;
        logic [ispf_pkg::BYTE_W-1:0] kind_byte;
        stop_at = bytes_sent + count;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_header(8'($urandom_range(0, 255)));
        while (bytes_sent < stop_at)
        begin
            case ($urandom_range(19))
                0, 1:
                begin
                    repeat ($urandom_range(1, 5))
                        send_byte(8'($urandom_range(0, 255)));
                end
                2:
                begin
                    send_byte(header_now);
                    repeat ($urandom_range(0, 9))
                        send_byte(8'($urandom_range(0, 255)));
                end
                3:
                begin
                    drain();
                end
                default:
                begin
                    case ($urandom_range(9))
                        0:       kind_byte = 8'($urandom_range(0, 255));
                        1, 2, 3: kind_byte = ispf_pkg::KIND_BYTE_ACCEL;
                        4, 5, 6: kind_byte = ispf_pkg::KIND_BYTE_RATE;
                        default: kind_byte = ispf_pkg::KIND_BYTE_ANGLE;
                    endcase
                    send_frame(kind_byte, {$urandom, $urandom}, $urandom_range(7) == 0);
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_known_kinds();
        test_bad_checksum();
        test_unknown_kind();
        test_header_inside_frame();
        test_header_values();
        test_random_traffic(600, 32, 83);
        test_random_traffic(600, 83, 32);
        test_random_traffic(600, 0, 0);
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
